### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/lpms_pkg.sv
// Shared types and constants of the lucky packet minimum delay selector.
package lpms_pkg;

   localparam int DEFAULT_MAX_WINDOW = 16;

   localparam int DELAY_W   = 64;
   localparam int TAG_W     = 16;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PICK_COUNT  = 4'd1;

   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd16;
   localparam logic [CFG_W-1:0] PICK_COUNT_RESET  = 5'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                      last;
      logic [TAG_W-1:0]          tag;
      logic signed [DELAY_W-1:0] delay;
   } rsp_item_type;

endpackage

### hw/rtl/lpms_store.sv
// Sample memory of the window: one write port and one registered read port.
module lpms_store import lpms_pkg::*; #(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic signed [DELAY_W-1:0] wr_delay,
   input  logic [TAG_W-1:0]          wr_tag,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic signed [DELAY_W-1:0] rd_delay,
   output logic [TAG_W-1:0]          rd_tag
);
   logic signed [DELAY_W-1:0] delay_mem [MAX_WINDOW];
   logic [TAG_W-1:0]          tag_mem [MAX_WINDOW];
   logic signed [DELAY_W-1:0] rd_delay_ff;
   logic [TAG_W-1:0]          rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         delay_mem[wr_addr] <= wr_delay;
         tag_mem[wr_addr]   <= wr_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_delay_ff <= delay_mem[rd_addr];
         rd_tag_ff   <= tag_mem[rd_addr];
      end
   end

   assign rd_delay = rd_delay_ff;
   assign rd_tag   = rd_tag_ff;

endmodule

### hw/rtl/lpms_scan.sv
// Fill control and selection sequencer: one scan over the window per picked item.
module lpms_scan import lpms_pkg::*; #(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CFG_W-1:0]          window_size,
   input  logic [CFG_W-1:0]          pick_count,
   output logic                      wr_en,
   output logic [AW-1:0]             wr_addr,
   output logic                      rd_en,
   output logic [AW-1:0]             rd_addr,
   input  logic signed [DELAY_W-1:0] rd_delay,
   input  logic [TAG_W-1:0]          rd_tag,
   input  logic                      out_free,
   output logic                      emit_valid,
   output rsp_item_type              emit_item
);
   localparam int FW = $clog2(MAX_WINDOW + 1);
   localparam int CW = (FW > CFG_W) ? FW : CFG_W;

   function automatic logic [DELAY_W-1:0] magnitude(input logic [DELAY_W-1:0] v);
      return v[DELAY_W-1] ? (~v + {{(DELAY_W-1){1'b0}}, 1'b1}) : v;
   endfunction

   state_type                 state_ff, state_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [FW-1:0]             n_ff, n_in;
   logic [FW-1:0]             picks_ff, picks_in;
   logic [FW-1:0]             k_ff, k_in;
   logic [FW-1:0]             iss_ff, iss_in;
   logic                      pend_ff, pend_in;
   logic [AW-1:0]             pend_idx_ff, pend_idx_in;
   logic                      found_ff, found_in;
   logic [DELAY_W-1:0]        best_mag_ff, best_mag_in;
   logic [AW-1:0]             best_idx_ff, best_idx_in;
   logic signed [DELAY_W-1:0] best_delay_ff, best_delay_in;
   logic [TAG_W-1:0]          best_tag_ff, best_tag_in;
   logic [MAX_WINDOW-1:0]     taken_ff, taken_in;

   logic [FW-1:0]             fill_nx;
   logic [CW-1:0]             eff_win;
   logic [CW-1:0]             picks_raw;
   logic [FW-1:0]             picks_sel;
   logic [DELAY_W-1:0]        mag_cur;
   logic                      last_pick;

   always_comb begin
      fill_nx = (fill_ff < FW'(MAX_WINDOW)) ? fill_ff + FW'(1) : fill_ff;
      if (window_size == '0) begin
         eff_win = CW'(1);
      end else if (CW'(window_size) > CW'(MAX_WINDOW)) begin
         eff_win = CW'(MAX_WINDOW);
      end else begin
         eff_win = CW'(window_size);
      end
      picks_raw = (pick_count == '0) ? CW'(1) : CW'(pick_count);
      picks_sel = (picks_raw > CW'(fill_nx)) ? fill_nx : picks_raw[FW-1:0];
      mag_cur   = magnitude(rd_delay);
      last_pick = (k_ff + FW'(1)) == picks_ff;
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      n_in          = n_ff;
      picks_in      = picks_ff;
      k_in          = k_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      pend_idx_in   = iss_ff[AW-1:0];
      found_in      = found_ff;
      best_mag_in   = best_mag_ff;
      best_idx_in   = best_idx_ff;
      best_delay_in = best_delay_ff;
      best_tag_in   = best_tag_ff;
      taken_in      = taken_ff;
      req_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[AW-1:0];
      rd_en         = 1'b0;
      rd_addr       = iss_ff[AW-1:0];
      emit_valid    = 1'b0;
      emit_item.delay = best_delay_ff;
      emit_item.tag   = best_tag_ff;
      emit_item.last  = last_pick;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               wr_en = fill_ff < FW'(MAX_WINDOW);
               if (CW'(fill_nx) >= eff_win) begin
                  fill_in  = '0;
                  n_in     = fill_nx;
                  picks_in = picks_sel;
                  k_in     = '0;
                  iss_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  fill_in = fill_nx;
               end
            end
         end
         ST_SCAN: begin
            rd_en = iss_ff < n_ff;
            if (rd_en) begin
               iss_in  = iss_ff + FW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && !taken_ff[pend_idx_ff] && (!found_ff || mag_cur < best_mag_ff)) begin
               found_in      = 1'b1;
               best_mag_in   = mag_cur;
               best_idx_in   = pend_idx_ff;
               best_delay_in = rd_delay;
               best_tag_in   = rd_tag;
            end
            if (!rd_en && !pend_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            emit_valid = out_free;
            if (out_free) begin
               k_in = k_ff + FW'(1);
               if (last_pick) begin
                  taken_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  taken_in[best_idx_ff] = 1'b1;
                  iss_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         taken_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         taken_ff <= taken_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      picks_ff      <= picks_in;
      k_ff          <= k_in;
      iss_ff        <= iss_in;
      pend_idx_ff   <= pend_idx_in;
      best_mag_ff   <= best_mag_in;
      best_idx_ff   <= best_idx_in;
      best_delay_ff <= best_delay_in;
      best_tag_ff   <= best_tag_in;
   end

endmodule

### hw/rtl/lucky_packet_min_delay_select.sv
// Top level of the lucky packet minimum delay selector.
//
//   Channel  Direction  Contents
//   req_     in         tdata: path_delay, sample_tag
//   rsp_     out        tdata: picked_delay, picked_tag; tlast: last_of_burst
//   csr_     in         write of window_size or pick_count
//
// An item that does not complete the window is written and the block stays ready.
// The item that completes a window of n entries starts a burst: each picked
// item costs one memory read per entry, a scan of the whole window, then an emit.
// Input is held off until the last item of the burst sits in the output register.
// A stalled output holds the sequencer before the next pick. Reset needs no clearing pass.
module lucky_packet_min_delay_select import lpms_pkg::*; #(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,   // path_delay [63:0], sample_tag [79:64]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [79:0]          rsp_tdata,   // picked_delay [63:0], picked_tag [79:64]
   output logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]     csr_wdata
);
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [CFG_W-1:0]          window_ff, window_in;
   logic [CFG_W-1:0]          pick_ff, pick_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_item_type              rsp_item_ff, rsp_item_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic signed [DELAY_W-1:0] rd_delay;
   logic [TAG_W-1:0]          rd_tag;
   logic                      out_free;
   logic                      emit_valid;
   rsp_item_type              emit_item;

   lpms_store #(
      .MAX_WINDOW(MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_delay(req_tdata[63:0]),
      .wr_tag  (req_tdata[79:64]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_delay(rd_delay),
      .rd_tag  (rd_tag)
   );

   lpms_scan #(
      .MAX_WINDOW(MAX_WINDOW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .window_size(window_ff),
      .pick_count (pick_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_delay   (rd_delay),
      .rd_tag     (rd_tag),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_item  (emit_item)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      window_in = window_ff;
      pick_in   = pick_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_WINDOW_SIZE: window_in = csr_wdata;
            REG_PICK_COUNT:  pick_in   = csr_wdata;
            default: begin
            end
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = emit_item;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_SIZE_RESET;
         pick_ff      <= PICK_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         pick_ff      <= pick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.tag, rsp_item_ff.delay};
   assign rsp_tlast  = rsp_item_ff.last;

endmodule

### hw/rtl/lpms_checker.sv
// Port-level checker of the selector and its bind to the top level.
`include "assert_macros.svh"

module lpms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);

   `ASSERT_RST(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "Stalled output item changed.")
   `ASSERT_RST(a_burst_blocks_input, clock, reset,
      rsp_tvalid && !rsp_tlast |-> !req_tready,
      "Input taken while a burst is still open.")
   `ASSERT_RST(a_handshake_known, clock, reset,
      !$isunknown(req_tready) && !$isunknown(rsp_tvalid),
      "Handshake output is unknown.")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "Output valid right after reset.")

endmodule

bind lucky_packet_min_delay_select lpms_checker u_lpms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
